// ===== rtl/core/fppc_pkg.sv =====
// ----------------------------------------------------------------------------
// fppc_pkg
// Shared constants, result codes, a CRC helper and a saturating increment of the parser.
// ----------------------------------------------------------------------------
package fppc_pkg;

    // Payload store depth and the widths that follow from it.
    localparam int MAX_PAYLOAD = 32;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

    // Fixed field widths of the result transaction.
    localparam int EV_W   = 3;
    localparam int PLEN_W = 6;
    localparam int IDX_W  = 5;
    localparam int CNT_W  = 16;

    // Result codes.
    localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EV_W-1:0] EV_GOOD    = 3'd1;
    localparam logic [EV_W-1:0] EV_CRC_ERR = 3'd2;
    localparam logic [EV_W-1:0] EV_VER_ERR = 3'd3;
    localparam logic [EV_W-1:0] EV_LEN_ERR = 3'd4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT        = 3'd3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // CRC-16/CCITT-FALSE update by one byte, MSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] c_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

// ===== rtl/core/fppc_ram.sv =====
// ----------------------------------------------------------------------------
// fppc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fppc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/framed_packet_parser_crc16.sv =====
// ----------------------------------------------------------------------------
// framed_packet_parser_crc16
// Start-pattern framed packet parser with CRC-16/CCITT-FALSE check.
// ----------------------------------------------------------------------------
// Each received byte is one input transaction and is taken whenever the result
// register is free or is being emptied in the same cycle; it yields one status
// result. The byte that completes a good frame with a nonempty payload instead
// starts a replay of the payload from the payload RAM: each payload result takes
// a RAM read and then a load of the result register, and no input is taken
// until the replay ends, also while the output stalls. The payload RAM is not
// cleared at reset; only entries written by the current frame are read.
// ----------------------------------------------------------------------------
module framed_packet_parser_crc16 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_we,
    input  logic [fppc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_rx_byte,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [fppc_pkg::EV_W-1:0]     o_event_res,
    output logic [7:0]                    o_frame_type,
    output logic [7:0]                    o_seq_number,
    output logic [fppc_pkg::PLEN_W-1:0]   o_frame_len,
    output logic                          o_payload_valid,
    output logic [7:0]                    o_payload_byte,
    output logic [fppc_pkg::IDX_W-1:0]    o_byte_index,
    output logic                          o_last,
    output logic [fppc_pkg::CNT_W-1:0]    o_good_frames,
    output logic [fppc_pkg::CNT_W-1:0]    o_crc_fail_count,
    output logic [fppc_pkg::CNT_W-1:0]    o_version_fail_count,
    output logic [fppc_pkg::CNT_W-1:0]    o_length_fail_count
);

    localparam int AW = fppc_pkg::ADDR_W;
    localparam int LW = fppc_pkg::LEN_W;
    localparam int CW = fppc_pkg::CNT_W;

    // Parse phases.
    localparam logic [1:0] PH_SCAN    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_CRC     = 2'd3;

    // Control states.
    localparam logic [1:0] S_IN = 2'd0;
    localparam logic [1:0] S_RD = 2'd1;
    localparam logic [1:0] S_LD = 2'd2;

    // Configuration registers.
    logic [7:0] r_start_first, r_start_second, r_exp_version;
    logic [5:0] r_payload_limit;

    // Parser state.
    logic [1:0]    r_phase, n_phase;
    logic [15:0]   r_hist, n_hist;
    logic [LW-1:0] r_fcnt, n_fcnt;
    logic [7:0]    r_hdr_version, n_hdr_version;
    logic [7:0]    r_hdr_type, n_hdr_type;
    logic [7:0]    r_hdr_seq, n_hdr_seq;
    logic [LW-1:0] r_hdr_len, n_hdr_len;
    logic [15:0]   r_crc, n_crc;
    logic [7:0]    r_crc_low, n_crc_low;
    logic [CW-1:0] r_good, n_good, r_crc_err, n_crc_err;
    logic [CW-1:0] r_ver_err, n_ver_err, r_len_err, n_len_err;

    logic [1:0]    r_ctl, n_ctl;
    logic [AW-1:0] r_idx, n_idx;

    // Result register.
    logic                        r_out_valid, n_out_valid;
    logic [fppc_pkg::EV_W-1:0]   r_ev, n_ev;
    logic [7:0]                  r_o_type, n_o_type, r_o_seq, n_o_seq;
    logic [fppc_pkg::PLEN_W-1:0] r_o_len, n_o_len;
    logic                        r_o_pv, n_o_pv;
    logic [7:0]                  r_o_byte, n_o_byte;
    logic [fppc_pkg::IDX_W-1:0]  r_o_idx, n_o_idx;
    logic                        r_o_last, n_o_last;
    logic [CW-1:0]               r_o_good, n_o_good, r_o_crc, n_o_crc;
    logic [CW-1:0]               r_o_ver, n_o_ver, r_o_lenc, n_o_lenc;

    logic          w_slot_free, w_in_acc, w_run_last;
    logic          w_ram_we, w_ram_re;
    logic [7:0]    w_ram_rdata;
    logic [15:0]   w_crc_fed;
    logic [LW-1:0] w_fcnt_inc;
    logic [15:0]   w_rx_crc;
    logic          w_len_bad;

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_ctl != S_IN) || !w_slot_free;
    assign w_in_acc    = i_in_valid && !o_in_stall;

    assign w_crc_fed  = fppc_pkg::crc_feed(r_crc, i_rx_byte);
    assign w_fcnt_inc = r_fcnt + 1'b1;
    assign w_rx_crc   = {i_rx_byte, r_crc_low};
    assign w_len_bad  = (i_rx_byte > {2'b00, r_payload_limit}) ||
                        (i_rx_byte > 8'(fppc_pkg::MAX_PAYLOAD));
    assign w_run_last = ({1'b0, r_idx} + 1'b1) == (AW + 1)'(r_hdr_len);

    // Payload bytes are written only while bytes are being taken, and the
    // replay reads only while input is held off, so the two never overlap.
    assign w_ram_we = w_in_acc && (r_phase == PH_PAYLOAD);
    assign w_ram_re = (r_ctl == S_RD);

    fppc_ram #(
        .WIDTH (8),
        .DEPTH (fppc_pkg::MAX_PAYLOAD)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_fcnt[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (w_ram_re),
        .i_raddr (r_idx),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        n_phase       = r_phase;
        n_hist        = r_hist;
        n_fcnt        = r_fcnt;
        n_hdr_version = r_hdr_version;
        n_hdr_type    = r_hdr_type;
        n_hdr_seq     = r_hdr_seq;
        n_hdr_len     = r_hdr_len;
        n_crc         = r_crc;
        n_crc_low     = r_crc_low;
        n_good        = r_good;
        n_crc_err     = r_crc_err;
        n_ver_err     = r_ver_err;
        n_len_err     = r_len_err;
        n_ctl         = r_ctl;
        n_idx         = r_idx;

        n_out_valid = r_out_valid && i_out_stall;
        n_ev        = r_ev;
        n_o_type    = r_o_type;
        n_o_seq     = r_o_seq;
        n_o_len     = r_o_len;
        n_o_pv      = r_o_pv;
        n_o_byte    = r_o_byte;
        n_o_idx     = r_o_idx;
        n_o_last    = r_o_last;
        n_o_good    = r_o_good;
        n_o_crc     = r_o_crc;
        n_o_ver     = r_o_ver;
        n_o_lenc    = r_o_lenc;

        case (r_ctl)
            S_IN: begin
                if (w_in_acc) begin
                    // Status result unless a payload replay starts below.
                    n_ev      = fppc_pkg::EV_NONE;
                    n_o_type  = '0;
                    n_o_seq   = '0;
                    n_o_len   = '0;
                    n_o_pv    = 1'b0;
                    n_o_byte  = '0;
                    n_o_idx   = '0;
                    n_o_last  = 1'b1;
                    n_out_valid = 1'b1;

                    case (r_phase)
                        PH_SCAN: begin
                            n_hist = {r_hist[7:0], i_rx_byte};
                            if (r_hist[7:0] == r_start_first &&
                                i_rx_byte == r_start_second) begin
                                n_phase = PH_HEADER;
                                n_fcnt  = '0;
                                n_crc   = fppc_pkg::CRC_INIT;
                            end
                        end
                        PH_HEADER: begin
                            n_crc  = w_crc_fed;
                            n_fcnt = w_fcnt_inc;
                            case (r_fcnt[1:0])
                                2'd0: n_hdr_version = i_rx_byte;
                                2'd1: n_hdr_type    = i_rx_byte;
                                2'd2: n_hdr_seq     = i_rx_byte;
                                default: begin
                                    n_hdr_len = i_rx_byte[LW-1:0];
                                    n_fcnt    = '0;
                                    if (r_hdr_version != r_exp_version) begin
                                        n_ver_err = fppc_pkg::sat_inc(r_ver_err);
                                        n_phase   = PH_SCAN;
                                        n_ev      = fppc_pkg::EV_VER_ERR;
                                    end else if (w_len_bad) begin
                                        n_len_err = fppc_pkg::sat_inc(r_len_err);
                                        n_phase   = PH_SCAN;
                                        n_ev      = fppc_pkg::EV_LEN_ERR;
                                    end else if (i_rx_byte != 8'd0) begin
                                        n_phase = PH_PAYLOAD;
                                    end else begin
                                        n_phase = PH_CRC;
                                    end
                                end
                            endcase
                        end
                        PH_PAYLOAD: begin
                            n_crc  = w_crc_fed;
                            n_fcnt = w_fcnt_inc;
                            if (w_fcnt_inc >= r_hdr_len) begin
                                n_phase = PH_CRC;
                                n_fcnt  = '0;
                            end
                        end
                        PH_CRC: begin
                            if (r_fcnt == '0) begin
                                n_crc_low = i_rx_byte;
                                n_fcnt    = LW'(1);
                            end else begin
                                n_fcnt  = '0;
                                n_phase = PH_SCAN;
                                if (w_rx_crc == r_crc) begin
                                    n_good = fppc_pkg::sat_inc(r_good);
                                    if (r_hdr_len == '0) begin
                                        n_ev     = fppc_pkg::EV_GOOD;
                                        n_o_type = r_hdr_type;
                                        n_o_seq  = r_hdr_seq;
                                    end else begin
                                        // Replay the payload from the RAM.
                                        n_out_valid = 1'b0;
                                        n_ctl       = S_RD;
                                        n_idx       = '0;
                                    end
                                end else begin
                                    n_crc_err = fppc_pkg::sat_inc(r_crc_err);
                                    n_ev      = fppc_pkg::EV_CRC_ERR;
                                end
                            end
                        end
                        default: n_phase = PH_SCAN;
                    endcase

                    n_o_good = n_good;
                    n_o_crc  = n_crc_err;
                    n_o_ver  = n_ver_err;
                    n_o_lenc = n_len_err;
                end
            end
            S_RD: begin
                n_ctl = S_LD;
            end
            S_LD: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_ev        = fppc_pkg::EV_GOOD;
                    n_o_type    = r_hdr_type;
                    n_o_seq     = r_hdr_seq;
                    n_o_len     = fppc_pkg::PLEN_W'(r_hdr_len);
                    n_o_pv      = 1'b1;
                    n_o_byte    = w_ram_rdata;
                    n_o_idx     = fppc_pkg::IDX_W'(r_idx);
                    n_o_last    = w_run_last;
                    n_o_good    = r_good;
                    n_o_crc     = r_crc_err;
                    n_o_ver     = r_ver_err;
                    n_o_lenc    = r_len_err;
                    if (w_run_last) begin
                        n_ctl = S_IN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        n_ctl = S_RD;
                    end
                end
            end
            default: n_ctl = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_first   <= 8'hAA;
            r_start_second  <= 8'h55;
            r_exp_version   <= 8'h01;
            r_payload_limit <= 6'd32;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fppc_pkg::CFG_START_FIRST:  r_start_first   <= i_cfg_data;
                fppc_pkg::CFG_START_SECOND: r_start_second  <= i_cfg_data;
                fppc_pkg::CFG_VERSION:      r_exp_version   <= i_cfg_data;
                fppc_pkg::CFG_LIMIT:        r_payload_limit <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SCAN;
            r_hist        <= '0;
            r_fcnt        <= '0;
            r_hdr_version <= '0;
            r_hdr_type    <= '0;
            r_hdr_seq     <= '0;
            r_hdr_len     <= '0;
            r_crc         <= fppc_pkg::CRC_INIT;
            r_crc_low     <= '0;
            r_good        <= '0;
            r_crc_err     <= '0;
            r_ver_err     <= '0;
            r_len_err     <= '0;
            r_ctl         <= S_IN;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_hist        <= n_hist;
            r_fcnt        <= n_fcnt;
            r_hdr_version <= n_hdr_version;
            r_hdr_type    <= n_hdr_type;
            r_hdr_seq     <= n_hdr_seq;
            r_hdr_len     <= n_hdr_len;
            r_crc         <= n_crc;
            r_crc_low     <= n_crc_low;
            r_good        <= n_good;
            r_crc_err     <= n_crc_err;
            r_ver_err     <= n_ver_err;
            r_len_err     <= n_len_err;
            r_ctl         <= n_ctl;
            r_idx         <= n_idx;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev     <= n_ev;
        r_o_type <= n_o_type;
        r_o_seq  <= n_o_seq;
        r_o_len  <= n_o_len;
        r_o_pv   <= n_o_pv;
        r_o_byte <= n_o_byte;
        r_o_idx  <= n_o_idx;
        r_o_last <= n_o_last;
        r_o_good <= n_o_good;
        r_o_crc  <= n_o_crc;
        r_o_ver  <= n_o_ver;
        r_o_lenc <= n_o_lenc;
    end

    assign o_out_valid          = r_out_valid;
    assign o_event_res          = r_ev;
    assign o_frame_type         = r_o_type;
    assign o_seq_number         = r_o_seq;
    assign o_frame_len          = r_o_len;
    assign o_payload_valid      = r_o_pv;
    assign o_payload_byte       = r_o_byte;
    assign o_byte_index         = r_o_idx;
    assign o_last               = r_o_last;
    assign o_good_frames        = r_o_good;
    assign o_crc_fail_count     = r_o_crc;
    assign o_version_fail_count = r_o_ver;
    assign o_length_fail_count  = r_o_lenc;

    // A payload result always belongs to a good frame.
    a_payload_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_pv) |-> (r_ev == fppc_pkg::EV_GOOD))
        else $error("payload result without good-frame event");

    // A RAM read is always followed by the load step that consumes it.
    a_rd_then_ld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl == S_RD) |=> (r_ctl == S_LD))
        else $error("replay read not followed by load");

    // The final payload result of a replay hands control back to the input.
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl == S_LD && w_slot_free && w_run_last) |=> (r_ctl == S_IN && r_o_last))
        else $error("payload replay did not end on its last byte");

    // The saturating good frame counter never goes backward.
    a_good_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_good >= $past(r_good)))
        else $error("good frame counter decreased");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the framed packet parser with CRC-16 check.
// ----------------------------------------------------------------------------
// A queue of received bytes feeds a bursty driver; every accepted byte runs
// through a local parser predictor that queues the status and payload results
// it should cause. A monitor compares every delivered result, field by field,
// with the oldest queued one. The run moves through several register settings,
// written only while the parser is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int HOLDOFF_AFTER  = 12;

    // Index past the end of the register list; the parser must ignore it.
    localparam logic [fppc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd6;

    // Predicted parse phases.
    localparam logic [1:0] P_SCAN    = 2'd0;
    localparam logic [1:0] P_HEADER  = 2'd1;
    localparam logic [1:0] P_PAYLOAD = 2'd2;
    localparam logic [1:0] P_CRC     = 2'd3;

    typedef struct packed {
        logic [fppc_pkg::EV_W-1:0]   evt;
        logic [7:0]                  frame_type;
        logic [7:0]                  seq_number;
        logic [fppc_pkg::PLEN_W-1:0] frame_len;
        logic                        payload_valid;
        logic [7:0]                  payload_byte;
        logic [fppc_pkg::IDX_W-1:0]  byte_index;
        logic                        last;
        logic [fppc_pkg::CNT_W-1:0]  good_frames;
        logic [fppc_pkg::CNT_W-1:0]  crc_fails;
        logic [fppc_pkg::CNT_W-1:0]  version_fails;
        logic [fppc_pkg::CNT_W-1:0]  length_fails;
    } t_status;

    logic                           i_clk;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [fppc_pkg::CFG_IDX_W-1:0] i_cfg_index = fppc_pkg::CFG_START_FIRST;
    logic [7:0]                     i_cfg_data  = 8'h00;
    logic                           i_in_valid  = 1'b0;
    logic [7:0]                     i_rx_byte   = 8'h00;
    logic                           i_out_stall = 1'b0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    logic [fppc_pkg::EV_W-1:0]      o_event_res;
    logic [7:0]                     o_frame_type;
    logic [7:0]                     o_seq_number;
    logic [fppc_pkg::PLEN_W-1:0]    o_frame_len;
    logic                           o_payload_valid;
    logic [7:0]                     o_payload_byte;
    logic [fppc_pkg::IDX_W-1:0]     o_byte_index;
    logic                           o_last;
    logic [fppc_pkg::CNT_W-1:0]     o_good_frames;
    logic [fppc_pkg::CNT_W-1:0]     o_crc_fail_count;
    logic [fppc_pkg::CNT_W-1:0]     o_version_fail_count;
    logic [fppc_pkg::CNT_W-1:0]     o_length_fail_count;

    framed_packet_parser_crc16 uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_rx_byte            (i_rx_byte),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_event_res          (o_event_res),
        .o_frame_type         (o_frame_type),
        .o_seq_number         (o_seq_number),
        .o_frame_len          (o_frame_len),
        .o_payload_valid      (o_payload_valid),
        .o_payload_byte       (o_payload_byte),
        .o_byte_index         (o_byte_index),
        .o_last               (o_last),
        .o_good_frames        (o_good_frames),
        .o_crc_fail_count     (o_crc_fail_count),
        .o_version_fail_count (o_version_fail_count),
        .o_length_fail_count  (o_length_fail_count)
    );

    // Shared bookkeeping between the stimulus, driver and monitor.
    logic [7:0] rx_q[$];
    t_status    status_q[$];
    int         rx_pushed       = 0;
    int         rx_accepted     = 0;
    int         results_checked = 0;
    int         fail_count      = 0;
    int         gap_max         = 0;
    int         stall_pct       = 0;

    // Register copies used by the predictor and the frame builder.
    logic [7:0] cfg_sof1    = 8'hAA;
    logic [7:0] cfg_sof2    = 8'h55;
    logic [7:0] cfg_version = 8'h01;
    logic [5:0] cfg_limit   = 6'd32;

    // Predicted parser state.
    logic [1:0]                 pp_phase   = P_SCAN;
    logic [15:0]                pp_history = 16'h0000;
    int                         pp_count   = 0;
    logic [7:0]                 pp_version = 8'h00;
    logic [7:0]                 pp_type    = 8'h00;
    logic [7:0]                 pp_seq     = 8'h00;
    logic [7:0]                 pp_len     = 8'h00;
    logic [15:0]                pp_crc     = fppc_pkg::CRC_INIT;
    logic [7:0]                 pp_crc_lo  = 8'h00;
    logic [7:0]                 pp_store[fppc_pkg::MAX_PAYLOAD];
    logic [fppc_pkg::CNT_W-1:0] pp_good    = '0;
    logic [fppc_pkg::CNT_W-1:0] pp_crc_err = '0;
    logic [fppc_pkg::CNT_W-1:0] pp_ver_err = '0;
    logic [fppc_pkg::CNT_W-1:0] pp_len_err = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Bit-serial CRC-16/CCITT-FALSE, one byte MSB first.
    function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ d[i];
            r  = {r[14:0], 1'b0} ^ (fb ? fppc_pkg::CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic logic [fppc_pkg::CNT_W-1:0] sat_bump(
            input logic [fppc_pkg::CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    task automatic push_status(input logic [fppc_pkg::EV_W-1:0] evt, input logic good,
                               input logic pv, input logic [7:0] pb,
                               input logic [fppc_pkg::IDX_W-1:0] idx, input logic last);
        t_status r;
        r.evt           = evt;
        r.frame_type    = good ? pp_type : 8'h00;
        r.seq_number    = good ? pp_seq : 8'h00;
        r.frame_len     = good ? pp_len[fppc_pkg::PLEN_W-1:0] : '0;
        r.payload_valid = pv;
        r.payload_byte  = pb;
        r.byte_index    = idx;
        r.last          = last;
        r.good_frames   = pp_good;
        r.crc_fails     = pp_crc_err;
        r.version_fails = pp_ver_err;
        r.length_fails  = pp_len_err;
        status_q.push_back(r);
    endtask

    // Advances the predicted parser by one received byte and queues the
    // results that byte should produce.
    task automatic track_rx_byte(input logic [7:0] b);
        logic [fppc_pkg::EV_W-1:0] evt;
        logic [15:0]               rx_crc;
        logic                      frame_done;
        evt        = fppc_pkg::EV_NONE;
        frame_done = 1'b0;
        case (pp_phase)
            P_SCAN: begin
                pp_history = {pp_history[7:0], b};
                if (pp_history == {cfg_sof1, cfg_sof2}) begin
                    pp_phase = P_HEADER;
                    pp_count = 0;
                    pp_crc   = fppc_pkg::CRC_INIT;
                end
            end
            P_HEADER: begin
                pp_crc = crc_next(pp_crc, b);
                case (pp_count)
                    0:       pp_version = b;
                    1:       pp_type    = b;
                    2:       pp_seq     = b;
                    default: pp_len     = b;
                endcase
                pp_count++;
                if (pp_count >= 4) begin
                    pp_count = 0;
                    // Version is judged before length.
                    if (pp_version != cfg_version) begin
                        pp_ver_err = sat_bump(pp_ver_err);
                        pp_phase   = P_SCAN;
                        evt        = fppc_pkg::EV_VER_ERR;
                    end else if (pp_len > cfg_limit || pp_len > fppc_pkg::MAX_PAYLOAD) begin
                        pp_len_err = sat_bump(pp_len_err);
                        pp_phase   = P_SCAN;
                        evt        = fppc_pkg::EV_LEN_ERR;
                    end else begin
                        pp_phase = (pp_len != 0) ? P_PAYLOAD : P_CRC;
                    end
                end
            end
            P_PAYLOAD: begin
                pp_crc = crc_next(pp_crc, b);
                if (pp_count < fppc_pkg::MAX_PAYLOAD) pp_store[pp_count] = b;
                pp_count = (pp_count + 1) & 'h7F;
                if (pp_count >= pp_len) begin
                    pp_phase = P_CRC;
                    pp_count = 0;
                end
            end
            P_CRC: begin
                if (pp_count == 0) begin
                    pp_crc_lo = b;
                    pp_count  = 1;
                end else begin
                    rx_crc   = {b, pp_crc_lo};
                    pp_count = 0;
                    pp_phase = P_SCAN;
                    if (rx_crc == pp_crc) begin
                        pp_good    = sat_bump(pp_good);
                        frame_done = 1'b1;
                        if (pp_len == 0) begin
                            push_status(fppc_pkg::EV_GOOD, 1'b1, 1'b0, 8'h00, '0, 1'b1);
                        end else begin
                            for (int i = 0; i < pp_len && i < fppc_pkg::MAX_PAYLOAD; i++)
                                push_status(fppc_pkg::EV_GOOD, 1'b1, 1'b1, pp_store[i],
                                            i[fppc_pkg::IDX_W-1:0], (i + 1 == pp_len));
                        end
                    end else begin
                        pp_crc_err = sat_bump(pp_crc_err);
                        evt        = fppc_pkg::EV_CRC_ERR;
                    end
                end
            end
            default: pp_phase = P_SCAN;
        endcase
        if (!frame_done) push_status(evt, 1'b0, 1'b0, 8'h00, '0, 1'b1);
    endtask

    task automatic queue_byte(input logic [7:0] b);
        rx_q.push_back(b);
        rx_pushed++;
    endtask

    task automatic queue_header(input logic [7:0] v, input logic [7:0] t,
                                input logic [7:0] s, input logic [7:0] l);
        queue_byte(cfg_sof1);
        queue_byte(cfg_sof2);
        queue_byte(v);
        queue_byte(t);
        queue_byte(s);
        queue_byte(l);
    endtask

    // With n_sof of 1 only the second start byte is sent, which relies on the
    // start history still holding a matching first byte.
    task automatic queue_frame(input int n_sof, input logic [7:0] v, input logic [7:0] t,
                               input logic [7:0] s, input int len, input logic corrupt);
        logic [15:0] c;
        logic [7:0]  d;
        if (n_sof == 2) queue_byte(cfg_sof1);
        queue_byte(cfg_sof2);
        queue_byte(v);
        queue_byte(t);
        queue_byte(s);
        queue_byte(len[7:0]);
        c = crc_next(crc_next(crc_next(crc_next(fppc_pkg::CRC_INIT, v), t), s), len[7:0]);
        for (int i = 0; i < len; i++) begin
            d = 8'($urandom_range(0, 255));
            queue_byte(d);
            c = crc_next(c, d);
        end
        if (corrupt) c = c ^ (16'h0001 << $urandom_range(0, 15));
        queue_byte(c[7:0]);
        queue_byte(c[15:8]);
    endtask

    // Mostly well-formed frames with random content, some noise and some
    // broken headers. Assumes the two start bytes differ.
    task automatic queue_random_traffic(input int n_bytes);
        int         first;
        int         len;
        int         cap;
        logic [7:0] ver;
        first = rx_pushed;
        cap   = (cfg_limit < 6) ? cfg_limit : 6;
        while (rx_pushed - first < n_bytes) begin
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
                1: queue_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                default: begin
                    ver = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                      : cfg_version;
                    case ($urandom_range(0, 19))
                        0:       len = cfg_limit + 1;
                        1:       len = (cfg_limit < fppc_pkg::MAX_PAYLOAD) ? cfg_limit
                                                                           : fppc_pkg::MAX_PAYLOAD;
                        default: len = $urandom_range(0, cap);
                    endcase
                    queue_frame(2, ver, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), len,
                                $urandom_range(0, 5) == 0);
                end
            endcase
        end
    endtask

    task automatic write_reg(input logic [fppc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            fppc_pkg::CFG_START_FIRST:  cfg_sof1    = val;
            fppc_pkg::CFG_START_SECOND: cfg_sof2    = val;
            fppc_pkg::CFG_VERSION:      cfg_version = val;
            fppc_pkg::CFG_LIMIT:        cfg_limit   = val[5:0];
            default: ;
        endcase
    endtask

    // Waits until every queued byte is taken and every result has arrived.
    task automatic settle();
        while (rx_accepted != rx_pushed) @(posedge i_clk);
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin : rx_driver
        int   burst_left;
        int   gap_left;
        logic nxt_valid;
        if (!i_rst_n) begin
            burst_left = 0;
            gap_left   = 0;
            i_in_valid <= 1'b0;
        end else begin
            nxt_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                track_rx_byte(i_rx_byte);
                rx_accepted++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (rx_q.size() != 0) begin
                    i_rx_byte <= rx_q.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
                    end
                end
            end
            i_in_valid <= nxt_valid;
        end
    end

    // Receiver stall pattern, with one long hold-off early in the run so the
    // parser backs up and stalls its input.
    always @(posedge i_clk) begin : result_stall
        int   holdoff_left;
        bit   holdoff_taken;
        int   stall_run;
        logic stall_now;
        if (!i_rst_n) begin
            holdoff_left  = 0;
            holdoff_taken = 1'b0;
            stall_run     = 0;
            stall_now     = 1'b0;
            i_out_stall <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_stall <= 1'b1;
        end else if (!holdoff_taken && results_checked >= HOLDOFF_AFTER) begin
            holdoff_taken = 1'b1;
            holdoff_left  = HOLDOFF_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            if (stall_run == 0) begin
                stall_now = ($urandom_range(0, 99) < stall_pct);
                stall_run = $urandom_range(1, 8);
            end
            stall_run--;
            i_out_stall <= stall_now;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_status want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_q.size() == 0) begin
                $display("%0t ns: result arrived with none expected, event expected none, got %0d",
                         $time, o_event_res);
                fail_count++;
            end else begin
                want = status_q.pop_front();
                check_field("event_res", want.evt, o_event_res);
                check_field("frame_type", want.frame_type, o_frame_type);
                check_field("seq_number", want.seq_number, o_seq_number);
                check_field("frame_len", want.frame_len, o_frame_len);
                check_field("payload_valid", want.payload_valid, o_payload_valid);
                check_field("payload_byte", want.payload_byte, o_payload_byte);
                check_field("byte_index", want.byte_index, o_byte_index);
                check_field("last", want.last, o_last);
                check_field("good_frames", want.good_frames, o_good_frames);
                check_field("crc_fail_count", want.crc_fails, o_crc_fail_count);
                check_field("version_fail_count", want.version_fails, o_version_fail_count);
                check_field("length_fail_count", want.length_fails, o_length_fail_count);
            end
            results_checked++;
        end
    end

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: good empty frame, version checked before length,
        // oversize length, a corrupted CRC, then random traffic.
        stall_pct = 30;
        gap_max   = 3;
        queue_frame(2, 8'h01, 8'hFF, 8'h00, 0, 1'b0);
        queue_header(8'h00, 8'h12, 8'h34, 8'hFF);
        queue_header(8'h01, 8'h80, 8'h7F, 8'd33);
        queue_frame(2, 8'h01, 8'h00, 8'hFF, 0, 1'b1);
        queue_random_traffic(12);
        settle();

        // Low extremes. With equal start bytes, the history left by one frame
        // lets a single start byte open the next one.
        write_reg(fppc_pkg::CFG_START_FIRST, 8'h00);
        write_reg(fppc_pkg::CFG_START_SECOND, 8'h00);
        write_reg(fppc_pkg::CFG_VERSION, 8'hFF);
        write_reg(fppc_pkg::CFG_LIMIT, 8'd0);
        write_reg(CFG_SPARE, 8'h5A);
        stall_pct = 20;
        gap_max   = 0;
        queue_frame(2, 8'hFF, 8'h11, 8'h22, 0, 1'b0);
        queue_frame(1, 8'hFF, 8'h33, 8'h44, 0, 1'b0);
        queue_header(8'hFF, 8'h00, 8'h00, 8'd1);
        queue_frame(1, 8'hFF, 8'h55, 8'h66, 0, 1'b1);
        settle();

        // High extremes: the largest payload, and a length the limit allows
        // but the payload store does not.
        write_reg(fppc_pkg::CFG_START_FIRST, 8'hFF);
        write_reg(fppc_pkg::CFG_START_SECOND, 8'hFF);
        write_reg(fppc_pkg::CFG_VERSION, 8'h00);
        write_reg(fppc_pkg::CFG_LIMIT, 8'd63);
        stall_pct = 70;
        gap_max   = 2;
        queue_frame(2, 8'h00, 8'hAB, 8'hCD, fppc_pkg::MAX_PAYLOAD, 1'b0);
        queue_header(8'h00, 8'h01, 8'h02, 8'(fppc_pkg::MAX_PAYLOAD + 1));
        settle();

        if (fail_count == 0 && status_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            if (status_q.size() != 0)
                $display("%0t ns: %0d expected results never arrived", $time, status_q.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
